### rtl/core/pfa_pkg.sv
// Shared types and codes of the partition fit allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package pfa_pkg;

	// Operation codes of an input transaction. Code 3 is unused.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Result status codes.
	localparam logic [2:0] ST_LOADED    = 3'd0;
	localparam logic [2:0] ST_ALLOCATED = 3'd1;
	localparam logic [2:0] ST_NO_FIT    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	// Placement policy codes. The unused code behaves as first fit.
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// Configuration register index.
	localparam logic REG_FIT_POLICY = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FINISH,
		S_OUTPUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       load_exec;
		logic       clear_exec;
		logic       scan_init;
		logic       scan_step;
		logic       commit;
		logic       set_result;
		logic [2:0] res_status;
		logic       out_load;
	} pfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic full;
		logic issue_done;
		logic pipe_busy;
		logic found;
	} pfa_stat_t;

endpackage

`default_nettype wire

### rtl/core/pfa_ctrl.sv
// Controller state machine of the partition fit allocator.
// Depends on pfa_pkg; drives the datapath through pfa_cmd_t commands.
`default_nettype none

module pfa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire pfa_pkg::pfa_stat_t stat,
	output pfa_pkg::pfa_cmd_t       cmd
);
	import pfa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_NO_FIT;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_OUTPUT;
				unique case (stat.op)
					OP_LOAD: begin
						cmd.set_result = 1'b1;
						if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.load_exec  = 1'b1;
							cmd.res_status = ST_LOADED;
						end
					end
					OP_ALLOC: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					OP_CLEAR: begin
						cmd.clear_exec = 1'b1;
						cmd.set_result = 1'b1;
						cmd.res_status = ST_CLEARED;
					end
					default: begin
						cmd.set_result = 1'b1;
						cmd.res_status = ST_NO_FIT;
					end
				endcase
			end
			S_SCAN: begin
				// Issue one read per cycle, then let the compare stage drain.
				if (!stat.issue_done) begin
					cmd.scan_step = 1'b1;
				end else if (!stat.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.set_result = 1'b1;
				if (stat.found) begin
					cmd.commit     = 1'b1;
					cmd.res_status = ST_ALLOCATED;
				end else begin
					cmd.res_status = ST_NO_FIT;
				end
				state_d = S_OUTPUT;
			end
			S_OUTPUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/pfa_dp.sv
// Datapath of the partition fit allocator: size table memory, scan and result registers.
// Depends on pfa_pkg; controlled by pfa_ctrl through pfa_cmd_t and pfa_stat_t.
`default_nettype none

module pfa_dp #(
	parameter int NUM_PARTS = 16,
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfa_pkg::pfa_cmd_t cmd,
	output pfa_pkg::pfa_stat_t     stat,
	input  wire logic [1:0]        fit_policy,
	input  wire logic [1:0]        operation,
	input  wire logic [15:0]       size_value,
	output logic [2:0]             status,
	output logic [3:0]             partition_index,
	output logic [15:0]            remaining_after
);
	import pfa_pkg::*;

	logic [15:0] mem [NUM_PARTS];

	op_t              op_q;
	logic [15:0]      req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [15:0]      rdata_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_q;
	logic [15:0]      best_val_q;
	logic [2:0]       res_status_q;
	logic [3:0]       res_idx_q;
	logic [15:0]      res_rem_q;
	logic [2:0]       out_status_q;
	logic [3:0]       out_idx_q;
	logic [15:0]      out_rem_q;

	logic        fits;
	logic        take;
	logic [15:0] best_left;

	assign fits      = rdata_s1 >= req_q;
	assign best_left = best_val_q - req_q;

	// A fitting entry replaces the current pick only where the policy asks for it.
	always_comb begin
		take = 1'b0;
		if (v_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy == POL_BEST) begin
				take = rdata_s1 < best_val_q;
			end else if (fit_policy == POL_WORST) begin
				take = rdata_s1 > best_val_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_exec) begin
			mem[count_q[IDX_W-1:0]] <= req_q;
		end else if (cmd.commit) begin
			mem[best_q] <= best_left;
		end
		if (cmd.scan_step) begin
			rdata_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load_exec) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.clear_exec) begin
				count_q <= '0;
			end
			if (cmd.scan_init) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_q <= scan_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			v_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			req_q <= size_value;
		end
		idx_s1 <= scan_q[IDX_W-1:0];
		if (take) begin
			best_q     <= idx_s1;
			best_val_q <= rdata_s1;
		end
		if (cmd.set_result) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_status)
				ST_LOADED: begin
					res_idx_q <= 4'(count_q);
					res_rem_q <= req_q;
				end
				ST_ALLOCATED: begin
					res_idx_q <= 4'(best_q);
					res_rem_q <= best_left;
				end
				default: begin
					res_idx_q <= '0;
					res_rem_q <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_rem_q    <= res_rem_q;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.full       = count_q == CNT_W'(NUM_PARTS);
		stat.issue_done = scan_q == count_q;
		stat.pipe_busy  = v_s1;
		stat.found      = found_q;
	end

	assign status          = out_status_q;
	assign partition_index = out_idx_q;
	assign remaining_after = out_rem_q;

endmodule

`default_nettype wire

### rtl/core/partition_fit_allocator.sv
// Top level of the partition fit allocator: configuration port, controller and datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dp.
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_ready   operation[1:0], size_value[15:0]
// output    out_valid / out_ready status[2:0], partition_index[3:0], remaining_after[15:0]
// config    APB write/read        paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A load, clear or unused operation passes from acceptance through the decode state,
// which sets the result register, to the output state, which loads the output register.
// An allocation first scans the size table through its single registered read port,
// one entry a cycle, then sets the result. Reset clears the partition count, the policy
// register and the handshake state; the size table itself is not cleared. The block takes
// one transaction at a time and takes the next one while a finished result still waits
// for out_ready; a second finished result holds the input off until the first is taken.

module partition_fit_allocator #(
	parameter int NUM_PARTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] size_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [3:0]       partition_index,
	output logic [15:0]      remaining_after,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pfa_pkg::*;

	// The index keeps at least one bit; the count also holds NUM_PARTS itself.
	localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int CNT_W = $clog2(NUM_PARTS + 1);

	logic [1:0] fit_policy_q;
	pfa_cmd_t   cmd;
	pfa_stat_t  stat;

	// Only register zero exists; writes to the upper word address are dropped.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POL_FIRST;
		end else if (psel && penable && pwrite && paddr[2] == REG_FIT_POLICY) begin
			fit_policy_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FIT_POLICY) ? {30'd0, fit_policy_q} : 32'd0;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfa_dp #(
		.NUM_PARTS (NUM_PARTS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.fit_policy      (fit_policy_q),
		.operation       (operation),
		.size_value      (size_value),
		.status          (status),
		.partition_index (partition_index),
		.remaining_after (remaining_after)
	);

	// An accepted transaction blocks the input until its work is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// Only loaded and allocated results carry an index and a remaining size.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_LOADED && status != ST_ALLOCATED)
		|-> (partition_index == 4'd0 && remaining_after == 16'd0))
		else $error("nonzero payload on a result without a partition");

	// A fresh result never carries a status outside the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (status <= ST_CLEARED))
		else $error("undefined status code");

endmodule

`default_nettype wire
